[rtl/arw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay window package
// Shared widths, disposition codes, item kinds and queue payload structs.
// ----------------------------------------------------------------------------
package arw_pkg;

    // Field widths fixed by the packet format
    localparam int SEQ_W  = 64;
    localparam int DISP_W = 3;

    // Default window size and queue depth
    localparam int WINDOW_BITS_DEF = 256;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Result codes
    typedef enum logic [DISP_W-1:0] {
        DISP_ACCEPTED  = 3'd0,
        DISP_DUPLICATE = 3'd1,
        DISP_TOO_OLD   = 3'd2,
        DISP_FUTURE    = 3'd3,
        DISP_AUTH_FAIL = 3'd4,
        DISP_INVALID   = 3'd5
    } t_disp;

    // Command codes on the input
    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Item kind decided by the front part
    typedef enum logic [1:0] {
        KIND_CHECK     = 2'd0,
        KIND_CLEAR     = 2'd1,
        KIND_INVALID   = 2'd2,
        KIND_AUTH_FAIL = 2'd3
    } t_kind;

    // Item handed from front to back
    typedef struct packed {
        t_kind              kind;
        logic [SEQ_W-1:0]   seq;
    } t_front_item;

    // Result item
    typedef struct packed {
        t_disp              disp;
        logic [SEQ_W-1:0]   top;
    } t_result;

endpackage

[rtl/arw_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small register queue
// Flop-based FIFO with push/full and pop/empty; head entry shown directly.
// ----------------------------------------------------------------------------
module arw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/arw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay front end
// Accepts items, screens clear, zero-sequence and auth-failed cases, and
// queues them for the window engine.
// ----------------------------------------------------------------------------
module arw_front #(
    parameter int QUEUE_DEPTH = arw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic                       i_command,
    input  logic [arw_pkg::SEQ_W-1:0]  i_sequence_req,
    input  logic                       i_auth_ok,
    input  logic                       i_pop,
    output arw_pkg::t_front_item       o_item,
    output logic                       o_empty
);

    arw_pkg::t_front_item item_in;

    // Screening order: clear, zero sequence, then auth
    always_comb begin
        item_in.seq = i_sequence_req;
        if (i_command == arw_pkg::CMD_CLEAR) begin
            item_in.kind = arw_pkg::KIND_CLEAR;
        end else if (i_sequence_req == '0) begin
            item_in.kind = arw_pkg::KIND_INVALID;
        end else if (!i_auth_ok) begin
            item_in.kind = arw_pkg::KIND_AUTH_FAIL;
        end else begin
            item_in.kind = arw_pkg::KIND_CHECK;
        end
    end

    // Queue toward the window engine
    arw_fifo #(
        .WIDTH ($bits(arw_pkg::t_front_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (item_in),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty)
    );

endmodule

[rtl/arw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay window engine
// Holds the top sequence and seen bitmap, classifies one queued item per
// cycle while the result queue has room, updates the window and queues the result.
// ----------------------------------------------------------------------------
module arw_back #(
    parameter int WINDOW_BITS = arw_pkg::WINDOW_BITS_DEF,
    parameter int QUEUE_DEPTH = arw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  arw_pkg::t_front_item       i_item,
    input  logic                       i_item_empty,
    output logic                       o_item_pop,
    input  logic                       i_pop,
    output arw_pkg::t_result           o_result,
    output logic                       o_empty
);

    localparam int IDX_W  = $clog2(WINDOW_BITS);
    localparam int DIST_W = $clog2(WINDOW_BITS + 1);
    localparam logic [arw_pkg::SEQ_W-1:0] WIN = arw_pkg::SEQ_W'(WINDOW_BITS);

    logic [arw_pkg::SEQ_W-1:0] r_top;
    logic [arw_pkg::SEQ_W-1:0] n_top;
    logic [WINDOW_BITS-1:0]    r_bits;
    logic [WINDOW_BITS-1:0]    n_bits;

    logic                      res_full;
    logic                      take;
    logic                      is_newer;
    logic [arw_pkg::SEQ_W-1:0] ahead;
    logic [arw_pkg::SEQ_W-1:0] behind;
    logic [IDX_W-1:0]          off_idx;
    logic [DIST_W-1:0]         slide_amt;
    arw_pkg::t_disp            disp;
    arw_pkg::t_result          result;

    assign take       = !i_item_empty && !res_full;
    assign o_item_pop = take;
    assign is_newer   = i_item.seq > r_top;
    assign ahead      = i_item.seq - r_top;
    assign behind     = r_top - i_item.seq;
    assign off_idx    = behind[IDX_W-1:0];
    assign slide_amt  = ahead[DIST_W-1:0];

    // Classify and compute the next window
    always_comb begin
        disp   = arw_pkg::DISP_INVALID;
        n_top  = r_top;
        n_bits = r_bits;
        case (i_item.kind)
            arw_pkg::KIND_CLEAR: begin
                disp   = arw_pkg::DISP_INVALID;
                n_top  = '0;
                n_bits = '0;
            end
            arw_pkg::KIND_INVALID: begin
                disp = arw_pkg::DISP_INVALID;
            end
            arw_pkg::KIND_AUTH_FAIL: begin
                disp = arw_pkg::DISP_AUTH_FAIL;
            end
            arw_pkg::KIND_CHECK: begin
                if (r_top == '0) begin
                    // empty window
                    if (i_item.seq > WIN) begin
                        disp = arw_pkg::DISP_FUTURE;
                    end else begin
                        disp   = arw_pkg::DISP_ACCEPTED;
                        n_top  = i_item.seq;
                        n_bits = WINDOW_BITS'(1);
                    end
                end else if (is_newer) begin
                    // slide up by the distance, mark the new top
                    if (ahead > WIN) begin
                        disp = arw_pkg::DISP_FUTURE;
                    end else begin
                        disp   = arw_pkg::DISP_ACCEPTED;
                        n_top  = i_item.seq;
                        n_bits = (r_bits << slide_amt) | WINDOW_BITS'(1);
                    end
                end else begin
                    // at or below the top
                    if (behind >= WIN) begin
                        disp = arw_pkg::DISP_TOO_OLD;
                    end else if (r_bits[off_idx]) begin
                        disp = arw_pkg::DISP_DUPLICATE;
                    end else begin
                        disp            = arw_pkg::DISP_ACCEPTED;
                        n_bits[off_idx] = 1'b1;
                    end
                end
            end
            default: begin
                disp = arw_pkg::DISP_INVALID;
            end
        endcase
        result.disp = disp;
        result.top  = n_top;
    end

    // Window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= '0;
            r_bits <= '0;
        end else if (take) begin
            r_top  <= n_top;
            r_bits <= n_bits;
        end
    end

    // Result queue
    arw_fifo #(
        .WIDTH ($bits(arw_pkg::t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (result),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

endmodule

[rtl/anti_replay_window_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay sliding window, top level
// Checks packet sequence numbers against a sliding window of seen bits.
// ----------------------------------------------------------------------------
// One result per item, one item per clock while the result queue has room.
// An item is written to the input queue, classified from its head and
// written to the result queue, whose head drives the result ports. The rate
// is set by the window engine: the top compare, the bitmap barrel shift and
// the bit lookup are combinational between the window state registers. Small
// queues on both sides let input and output stall independently. A clear
// item empties the window and reports invalid with a zero top.
// ----------------------------------------------------------------------------
module anti_replay_window_top #(
    parameter int WINDOW_BITS = arw_pkg::WINDOW_BITS_DEF,
    parameter int QUEUE_DEPTH = arw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_command,
    input  logic [arw_pkg::SEQ_W-1:0]    i_sequence_req,
    input  logic                         i_auth_ok,
    output logic                         empty,
    input  logic                         pop,
    output logic [arw_pkg::DISP_W-1:0]   o_disposition,
    output logic [arw_pkg::SEQ_W-1:0]    o_window_top
);

    arw_pkg::t_front_item front_item;
    logic                 front_empty;
    logic                 front_pop;
    arw_pkg::t_result     result;

    // Front end: screening and input queue
    arw_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_command      (i_command),
        .i_sequence_req (i_sequence_req),
        .i_auth_ok      (i_auth_ok),
        .i_pop          (front_pop),
        .o_item         (front_item),
        .o_empty        (front_empty)
    );

    // Back end: window engine and result queue
    arw_back #(
        .WINDOW_BITS (WINDOW_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (front_item),
        .i_item_empty (front_empty),
        .o_item_pop   (front_pop),
        .i_pop        (pop),
        .o_result     (result),
        .o_empty      (empty)
    );

    assign o_disposition = result.disp;
    assign o_window_top  = result.top;

endmodule
